/* src/dtu_pkg.sv */
package dtu_pkg;

  localparam int BP_N = 64;
  localparam int BP_AW = (BP_N > 1) ? $clog2(BP_N) : 1;
  localparam int BP_CW = $clog2(BP_N + 1);
  localparam int TH_N = 16;
  localparam int TH_AW = (TH_N > 1) ? $clog2(TH_N) : 1;
  localparam int ARM_W = $clog2(TH_N + 1);

  localparam int IN_DW = 104;
  localparam int OUT_DW = 40;

  localparam logic [2:0] FUNC_EVENT = 3'd0;
  localparam logic [2:0] FUNC_SET = 3'd1;
  localparam logic [2:0] FUNC_CLEAR = 3'd2;
  localparam logic [2:0] FUNC_PAUSE = 3'd3;
  localparam logic [2:0] FUNC_RESUME = 3'd4;

  localparam logic [1:0] MODE_CONT = 2'd0;
  localparam logic [1:0] MODE_OVER = 2'd2;
  localparam logic [1:0] MODE_OUT = 2'd3;

  typedef struct packed {
    logic capture;
    logic prep;
    logic ev;
    logic rd;
    logic chk;
    logic fin;
    logic res;
    logic ld_out;
  } dtu_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       ev_go;
    logic       step_nz;
    logic       scan_end;
    logic       match;
    logic       res_found;
  } dtu_sts_t;

endpackage

/* src/dtu_datapath.sv */
module dtu_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dtu_pkg::dtu_cmd_t         cmd,
  output dtu_pkg::dtu_sts_t         sts,
  input  logic [dtu_pkg::IN_DW-1:0] in_data,
  input  logic [2:0]                in_func,
  input  logic                      enabled,
  output logic [dtu_pkg::OUT_DW-1:0] out_data
);
  import dtu_pkg::*;

  logic [2:0]  func_r;
  logic [15:0] tid_r, fid_r, ln_r, dep_r;
  logic        list_r, any_r;
  logic [31:0] id_r;
  logic [1:0]  mode_r;

  logic [BP_CW-1:0] bp_used_r;
  logic [BP_CW-1:0] scan_i_r;
  logic [31:0]      next_id_r;
  logic [16:0]      owner_r [TH_N];
  logic [48:0]      step_key_r [TH_N];
  logic [48:0]      sup_key_r [TH_N];
  logic [1:0]       kind_r [TH_N];
  logic [15:0]      mark_r [TH_N];
  logic [ARM_W-1:0] armed_r;
  logic [16:0]      pend_r;
  logic [TH_N-1:0]  busy_r;
  logic [63:0]      slot_info_r [TH_N];
  logic [63:0]      bp_mem [BP_N];
  logic [63:0]      rd_q;

  logic [TH_AW-1:0] t_r;
  logic [48:0]      sup_r;
  logic             hit_r;
  logic [63:0]      rinfo_r;

  logic        res_paused_r, res_ok_r;
  logic [3:0]  res_slot_r;
  logic [31:0] res_newid_r;
  logic [OUT_DW-1:0] out_r;

  logic [16:0]      tid_key, stid_key, key_sel;
  logic [48:0]      me, rme, sup_cur, sk;
  logic             t_hit, free_hit, claim_ok, ev_valid;
  logic [TH_AW-1:0] t_idx, free_idx, claim_idx, res_idx, fs_idx;
  logic             res_found, fs_ok;
  logic [1:0]       kind;
  logic [15:0]      mark;
  logic             depth_pass, line_ok, step_hit, pend_hit;
  logic [31:0]      rd_id;
  logic [15:0]      rd_file, rd_line;
  logic             scan_end, match, room;
  logic             wr_en;
  logic [BP_AW-1:0] wr_addr;
  logic [63:0]      wr_data;
  logic             active;

  assign tid_key  = {1'b0, tid_r} + 17'd1;
  assign stid_key = {1'b0, rinfo_r[63:48]} + 17'd1;
  assign key_sel  = cmd.res ? stid_key : tid_key;
  assign me       = {tid_key, fid_r, ln_r};
  assign rme      = {stid_key, rinfo_r[47:16]};
  assign ev_valid = list_r && (fid_r != 16'd0) && (ln_r != 16'd0);

  always_comb begin
    t_hit = 1'b0;
    t_idx = '0;
    free_hit = 1'b0;
    free_idx = '0;
    res_found = 1'b0;
    res_idx = '0;
    fs_ok = 1'b0;
    fs_idx = '0;
    for (int i = TH_N - 1; i >= 0; i--) begin
      if (owner_r[i] == key_sel) begin
        t_hit = 1'b1;
        t_idx = TH_AW'(i);
      end
      if (owner_r[i] == 17'd0) begin
        free_hit = 1'b1;
        free_idx = TH_AW'(i);
      end
      if (busy_r[i] && (any_r || slot_info_r[i][63:48] == tid_r)) begin
        res_found = 1'b1;
        res_idx = TH_AW'(i);
      end
      if (!busy_r[i]) begin
        fs_ok = 1'b1;
        fs_idx = TH_AW'(i);
      end
    end
  end

  assign claim_idx = t_hit ? t_idx : free_idx;
  assign claim_ok  = t_hit || free_hit;
  assign sup_cur   = sup_key_r[claim_idx];

  assign sk       = step_key_r[t_r];
  assign kind     = kind_r[t_r];
  assign mark     = mark_r[t_r];
  assign depth_pass = (kind == MODE_OVER) ? (dep_r <= mark) :
                      ((kind == MODE_OUT) ? (dep_r < mark) : 1'b1);
  assign line_ok  = (sk != me) || (kind == MODE_OUT);
  assign step_hit = depth_pass && line_ok;
  assign pend_hit = (pend_r != 17'd0) && (pend_r != tid_key);

  assign rd_id   = rd_q[63:32];
  assign rd_file = rd_q[31:16];
  assign rd_line = rd_q[15:0];
  assign scan_end = (scan_i_r == bp_used_r);
  assign room     = (bp_used_r < BP_CW'(BP_N));

  always_comb begin
    case (func_r)
      FUNC_EVENT: match = (rd_file == fid_r) && (rd_line == ln_r);
      FUNC_SET:   match = (rd_file == 16'd0);
      FUNC_CLEAR: match = (rd_id == id_r) && (rd_file != 16'd0);
      default:    match = 1'b0;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = scan_i_r[BP_AW-1:0];
    wr_data = {next_id_r + 32'd1, fid_r, ln_r};
    if (cmd.rd && scan_end && func_r == FUNC_SET && room) begin
      wr_en = 1'b1;
      wr_addr = bp_used_r[BP_AW-1:0];
    end else if (cmd.chk && match && func_r == FUNC_SET) begin
      wr_en = 1'b1;
    end else if (cmd.chk && match && func_r == FUNC_CLEAR) begin
      wr_en = 1'b1;
      wr_data = {rd_id, 16'd0, rd_line};
    end
  end

  assign sts.func      = func_r;
  assign sts.ev_go     = ev_valid && claim_ok;
  assign sts.step_nz   = (sk != 49'd0);
  assign sts.scan_end  = scan_end;
  assign sts.match     = match;
  assign sts.res_found = res_found;

  assign active = enabled && ((bp_used_r != '0) || (armed_r != '0) || (pend_r != 17'd0));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      tid_r  <= in_data[15:0];
      fid_r  <= in_data[31:16];
      ln_r   <= in_data[47:32];
      dep_r  <= in_data[63:48];
      list_r <= in_data[64];
      id_r   <= in_data[96:65];
      mode_r <= in_data[98:97];
      any_r  <= in_data[99];
    end
    if (wr_en) begin
      bp_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd && !scan_end) begin
      rd_q <= bp_mem[scan_i_r[BP_AW-1:0]];
    end
    if (cmd.prep) begin
      t_r <= claim_idx;
      sup_r <= ((sup_cur != 49'd0) && (sup_cur != me)) ? 49'd0 : sup_cur;
      rinfo_r <= slot_info_r[res_idx];
    end
    if (cmd.fin && (hit_r || pend_hit) && fs_ok) begin
      slot_info_r[fs_idx] <= {tid_r, fid_r, ln_r, dep_r};
    end
    if (cmd.ld_out) begin
      out_r <= {1'b0, active, res_ok_r, res_newid_r, res_slot_r, res_paused_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_used_r <= '0;
      scan_i_r <= '0;
      next_id_r <= '0;
      armed_r <= '0;
      pend_r <= '0;
      busy_r <= '0;
      hit_r <= 1'b0;
      res_paused_r <= 1'b0;
      res_ok_r <= 1'b0;
      res_slot_r <= '0;
      res_newid_r <= '0;
      for (int i = 0; i < TH_N; i++) begin
        owner_r[i] <= '0;
        step_key_r[i] <= '0;
        sup_key_r[i] <= '0;
        kind_r[i] <= '0;
        mark_r[i] <= '0;
      end
    end else begin
      if (cmd.prep) begin
        scan_i_r <= '0;
        hit_r <= 1'b0;
        res_paused_r <= 1'b0;
        res_ok_r <= 1'b0;
        res_slot_r <= '0;
        res_newid_r <= '0;
        if (func_r == FUNC_EVENT && ev_valid && claim_ok) begin
          if (!t_hit) begin
            owner_r[claim_idx] <= tid_key;
          end
          if ((sup_cur != 49'd0) && (sup_cur != me)) begin
            sup_key_r[claim_idx] <= '0;
          end
        end
        if (func_r == FUNC_PAUSE) begin
          pend_r <= tid_key;
        end
        if (func_r == FUNC_RESUME && res_found) begin
          busy_r[res_idx] <= 1'b0;
          res_ok_r <= 1'b1;
          res_slot_r <= 4'(res_idx);
        end
      end
      if (cmd.ev && sk != 49'd0 && step_hit) begin
        step_key_r[t_r] <= '0;
        hit_r <= 1'b1;
        if (armed_r != '0) begin
          armed_r <= armed_r - ARM_W'(1);
        end
      end
      if (cmd.rd && scan_end && func_r == FUNC_SET && room) begin
        bp_used_r <= bp_used_r + BP_CW'(1);
        next_id_r <= next_id_r + 32'd1;
        res_newid_r <= next_id_r + 32'd1;
      end
      if (cmd.chk) begin
        if (!match) begin
          scan_i_r <= scan_i_r + BP_CW'(1);
        end else if (func_r == FUNC_EVENT) begin
          hit_r <= (sup_r != me);
        end else if (func_r == FUNC_SET) begin
          next_id_r <= next_id_r + 32'd1;
          res_newid_r <= next_id_r + 32'd1;
        end else if (func_r == FUNC_CLEAR) begin
          res_ok_r <= 1'b1;
        end
      end
      if (cmd.fin) begin
        if (!hit_r && pend_hit) begin
          pend_r <= '0;
        end
        if ((hit_r || pend_hit) && fs_ok) begin
          busy_r[fs_idx] <= 1'b1;
          res_paused_r <= 1'b1;
          res_slot_r <= 4'(fs_idx);
        end
      end
      if (cmd.res && t_hit) begin
        sup_key_r[t_idx] <= rme;
        if (mode_r != MODE_CONT) begin
          kind_r[t_idx] <= mode_r;
          mark_r[t_idx] <= rinfo_r[15:0];
          step_key_r[t_idx] <= rme;
          if (step_key_r[t_idx] == 49'd0) begin
            armed_r <= armed_r + ARM_W'(1);
          end
        end
      end
    end
  end

  assign out_data = out_r;

endmodule

/* src/dtu_ctrl.sv */
module dtu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  dtu_pkg::dtu_sts_t sts,
  output dtu_pkg::dtu_cmd_t cmd
);
  import dtu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_event;

  assign is_event = (sts.func == FUNC_EVENT);
  assign in_tready = (state_r == S_IDLE) && rst_n;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.capture = in_tvalid && in_tready;
    cmd.prep = (state_r == S_PREP);
    cmd.ev = (state_r == S_EV);
    cmd.rd = (state_r == S_RD);
    cmd.chk = (state_r == S_CHK);
    cmd.fin = (state_r == S_FIN);
    cmd.res = (state_r == S_RES);
    cmd.ld_out = (state_r == S_OUT) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_PREP;
      end
      S_PREP: begin
        case (sts.func)
          FUNC_EVENT:  state_nxt = sts.ev_go ? S_EV : S_OUT;
          FUNC_SET:    state_nxt = S_RD;
          FUNC_CLEAR:  state_nxt = S_RD;
          FUNC_RESUME: state_nxt = sts.res_found ? S_RES : S_OUT;
          default:     state_nxt = S_OUT;
        endcase
      end
      S_EV: begin
        state_nxt = sts.step_nz ? S_FIN : S_RD;
      end
      S_RD: begin
        if (sts.scan_end) state_nxt = is_event ? S_FIN : S_OUT;
        else state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.match) state_nxt = is_event ? S_FIN : S_OUT;
        else state_nxt = S_RD;
      end
      S_FIN: state_nxt = S_OUT;
      S_RES: state_nxt = S_OUT;
      S_OUT: begin
        if (cmd.ld_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.ld_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/debug_trigger_unit.sv */
// Trigger logic of a debugger. Items arrive on the in_ stream: in_tuser holds
// the command and in_tdata the thread, location, depth, breakpoint id and
// resume fields. Each item gives exactly one result item on the out_ stream.
// Write the one-bit enabled register through cfg_valid, cfg_ready and cfg_data
// only while the block is idle; the block itself does not enforce this.
// An item is taken into the input registers and its result is loaded into
// the output register after the work below: a pause request, an ignored
// event or a resume that finds no paused thread goes from PREP straight to
// OUT, a resume that frees a slot passes RES and an event with an armed step
// passes EV and FIN. A set, a clear or an event with no armed step scans the
// breakpoint memory, each entry read by its registered read port, then checked.
// The next item is accepted while a result waits in the output register; when
// the receiver stalls with a result still waiting, the next result holds in
// its last state until the register frees.
// Reset clears the breakpoint count, ids, thread states, pause slots and the
// pending pause request; it takes effect at once and needs no clearing pass.
module debug_trigger_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // thread_id, file_id, line, stack_depth, is_list_form, bp_id, resume_mode,
  // resume_any, zero fill
  input  logic [dtu_pkg::IN_DW-1:0]   in_tdata,
  // func
  input  logic [2:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // paused, slot_index, new_bp_id, ok, active, zero fill
  output logic [dtu_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);
  import dtu_pkg::*;

  dtu_cmd_t cmd;
  dtu_sts_t sts;
  logic     enabled_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enabled_r <= cfg_data;
    end
  end

  dtu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dtu_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_tdata),
    .in_func  (in_tuser),
    .enabled  (enabled_r),
    .out_data (out_tdata)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second item while one is in work");

  a_active_gate: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out && !enabled_r |=> !out_tdata[38])
    else $error("active reported while disabled");

  a_pause_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[37] && out_tdata[36:5] == 32'd0)
    else $error("pause result carries other results");

endmodule
